FILE: rtl/ecpa_pkg.sv
package ecpa_pkg;

    localparam int FIELD_BITS  = 31;
    localparam int SCALAR_BITS = 32;
    localparam int CNT_W       = $clog2(FIELD_BITS);
    localparam int PADDR_W     = 4;

    typedef logic [FIELD_BITS-1:0]  fe_t;
    typedef logic [SCALAR_BITS-1:0] scalar_t;

    localparam fe_t MODULUS_RESET = {FIELD_BITS{1'b1}};
    localparam fe_t MIN_MODULUS   = fe_t'(5);
    localparam fe_t FE_ONE        = fe_t'(1);
    localparam fe_t FE_THREE      = fe_t'(3);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CURVE_A = 2'd0;
    localparam logic [1:0] REG_CURVE_B = 2'd1;
    localparam logic [1:0] REG_MODULUS = 2'd2;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef struct packed {
        logic    opcode;
        fe_t     first_x;
        fe_t     first_y;
        logic    first_at_infinity;
        fe_t     second_x;
        fe_t     second_y;
        logic    second_at_infinity;
        scalar_t scalar;
    } cmd_t;

    typedef struct packed {
        fe_t  result_x;
        fe_t  result_y;
        logic result_at_infinity;
        logic point_error;
    } res_t;

    // Both operands must already be below p.
    function automatic fe_t addm(input fe_t u, input fe_t v, input fe_t p);
        logic [FIELD_BITS:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, p})
        begin
            s = s - {1'b0, p};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    function automatic fe_t subm(input fe_t u, input fe_t v, input fe_t p);
        fe_t d;
        if (u >= v)
        begin
            d = u - v;
        end
        else
        begin
            d = u + (p - v);
        end
        return d;
    endfunction

endpackage

FILE: rtl/ec_point_add_and_scalar_multiply.sv
// An add reduces the six inputs mod p, checks both points against the curve and runs one point
// operation. A point operation may include an inverse by extended Euclid steps, and all
// products run on one bit-serial multiplier.
// A scalar multiply runs up to 2*SCALAR_BITS-1 point operations. One item at a time: busy is
// high from the accepted start and low again in the cycle of the done strobe; the receiver cannot stall.
// Reset clears the control state and sets curve_a = 0, curve_b = 0, modulus = 2^31 - 1.
module ec_point_add_and_scalar_multiply (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ecpa_pkg::cmd_t                 cmd,
    output logic                           done,
    output ecpa_pkg::res_t                 result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ecpa_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ecpa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_RED_W, S_CHK0, S_CHK1, S_CHK2, S_CHK3, S_CHK4, S_CHK_OK,
        S_LOOP0, S_LOOP1, S_ADD0, S_ADD1, S_ADD2, S_INV_T, S_INV_D, S_INV_M, S_INV_U,
        S_ADD4, S_ADD5, S_ADD6, S_ADD_DONE, S_MUL, S_FIN
    } state_t;

    state_t  state_reg, ret_reg;
    fe_t     cfg_a_reg, cfg_b_reg, cfg_p_reg;
    fe_t     p_reg, a_reg, b_reg;
    fe_t     fx_reg, fy_reg, sx_reg, sy_reg;
    logic    finf_reg, sinf_reg, op_reg;
    scalar_t d_reg;
    logic [2:0] red_idx_reg;
    logic    chk_sel_reg, err_reg, phase_acc_reg;
    fe_t     t0_reg, t1_reg, k_reg;
    fe_t     ux_reg, uy_reg, vx_reg, vy_reg;
    logic    uinf_reg, vinf_reg;
    fe_t     rx_reg, ry_reg;
    logic    rinf_reg;
    fe_t     ax_reg, ay_reg, px_reg, py_reg;
    logic    ainf_reg, pinf_reg;
    fe_t     r0_reg, r1_reg, s0_reg, s1_reg, q_reg, rem_reg;
    fe_t     mul_a_reg, mul_b_reg, mul_r_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic    done_reg;
    res_t    result_reg;

    fe_t     red_src, cx, cy, rx_new, st_new;
    logic    cinf;
    logic [FIELD_BITS:0] rem_w;
    logic    cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CURVE_A: prdata = 32'(cfg_a_reg);
            REG_CURVE_B: prdata = 32'(cfg_b_reg);
            REG_MODULUS: prdata = 32'(cfg_p_reg);
            default:     prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        unique case (red_idx_reg)
            3'd0:    red_src = a_reg;
            3'd1:    red_src = b_reg;
            3'd2:    red_src = fx_reg;
            3'd3:    red_src = fy_reg;
            3'd4:    red_src = sx_reg;
            default: red_src = sy_reg;
        endcase
        cx     = chk_sel_reg ? sx_reg : fx_reg;
        cy     = chk_sel_reg ? sy_reg : fy_reg;
        cinf   = chk_sel_reg ? sinf_reg : finf_reg;
        rx_new = subm(subm(mul_r_reg, ux_reg, p_reg), vx_reg, p_reg);
        st_new = subm(s0_reg, mul_r_reg, p_reg);
        rem_w  = {rem_reg, q_reg[FIELD_BITS-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_a_reg <= '0;
            cfg_b_reg <= '0;
            cfg_p_reg <= MODULUS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_CURVE_A: cfg_a_reg <= pwdata[FIELD_BITS-1:0];
                REG_CURVE_B: cfg_b_reg <= pwdata[FIELD_BITS-1:0];
                REG_MODULUS: cfg_p_reg <= pwdata[FIELD_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            mul_r_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            // The product accumulator is cleared whenever the multiplier is not running;
            // the return state still sees the finished product.
            if (state_reg != S_MUL)
            begin
                mul_r_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg      <= cmd.opcode;
                        fx_reg      <= cmd.first_x;
                        fy_reg      <= cmd.first_y;
                        finf_reg    <= cmd.first_at_infinity;
                        sx_reg      <= cmd.second_x;
                        sy_reg      <= cmd.second_y;
                        sinf_reg    <= cmd.second_at_infinity;
                        d_reg       <= cmd.scalar;
                        p_reg       <= cfg_p_reg;
                        a_reg       <= cfg_a_reg;
                        b_reg       <= cfg_b_reg;
                        red_idx_reg <= 3'd0;
                        chk_sel_reg <= 1'b0;
                        err_reg     <= 1'b0;
                        rinf_reg    <= 1'b1;
                        if (cfg_p_reg < MIN_MODULUS)
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_RED;
                        end
                    end
                end
                S_RED:
                begin
                    // Reduction mod p is a product with one.
                    mul_a_reg <= FE_ONE;
                    mul_b_reg <= red_src;
                    ret_reg   <= S_RED_W;
                    state_reg <= S_MUL;
                end
                S_RED_W:
                begin
                    unique case (red_idx_reg)
                        3'd0:    a_reg  <= mul_r_reg;
                        3'd1:    b_reg  <= mul_r_reg;
                        3'd2:    fx_reg <= mul_r_reg;
                        3'd3:    fy_reg <= mul_r_reg;
                        3'd4:    sx_reg <= mul_r_reg;
                        default: sy_reg <= mul_r_reg;
                    endcase
                    if (red_idx_reg == 3'd5)
                    begin
                        state_reg <= S_CHK0;
                    end
                    else
                    begin
                        red_idx_reg <= red_idx_reg + 3'd1;
                        state_reg   <= S_RED;
                    end
                end
                S_CHK0:
                begin
                    if (cinf)
                    begin
                        state_reg <= S_CHK_OK;
                    end
                    else
                    begin
                        mul_a_reg <= cy;
                        mul_b_reg <= cy;
                        ret_reg   <= S_CHK1;
                        state_reg <= S_MUL;
                    end
                end
                S_CHK1:
                begin
                    t1_reg    <= mul_r_reg;
                    mul_a_reg <= cx;
                    mul_b_reg <= cx;
                    ret_reg   <= S_CHK2;
                    state_reg <= S_MUL;
                end
                S_CHK2:
                begin
                    mul_a_reg <= mul_r_reg;
                    mul_b_reg <= cx;
                    ret_reg   <= S_CHK3;
                    state_reg <= S_MUL;
                end
                S_CHK3:
                begin
                    t0_reg    <= mul_r_reg;
                    mul_a_reg <= a_reg;
                    mul_b_reg <= cx;
                    ret_reg   <= S_CHK4;
                    state_reg <= S_MUL;
                end
                S_CHK4:
                begin
                    if (t1_reg == addm(addm(t0_reg, mul_r_reg, p_reg), b_reg, p_reg))
                    begin
                        state_reg <= S_CHK_OK;
                    end
                    else
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_CHK_OK:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (!chk_sel_reg)
                        begin
                            chk_sel_reg <= 1'b1;
                            state_reg   <= S_CHK0;
                        end
                        else
                        begin
                            ux_reg    <= fx_reg;
                            uy_reg    <= fy_reg;
                            uinf_reg  <= finf_reg;
                            vx_reg    <= sx_reg;
                            vy_reg    <= sy_reg;
                            vinf_reg  <= sinf_reg;
                            state_reg <= S_ADD0;
                        end
                    end
                    else
                    begin
                        ainf_reg  <= 1'b1;
                        ax_reg    <= '0;
                        ay_reg    <= '0;
                        px_reg    <= fx_reg;
                        py_reg    <= fy_reg;
                        pinf_reg  <= finf_reg;
                        state_reg <= S_LOOP0;
                    end
                end
                S_LOOP0:
                begin
                    if (d_reg == '0)
                    begin
                        rinf_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else if (d_reg[0])
                    begin
                        ux_reg        <= ax_reg;
                        uy_reg        <= ay_reg;
                        uinf_reg      <= ainf_reg;
                        vx_reg        <= px_reg;
                        vy_reg        <= py_reg;
                        vinf_reg      <= pinf_reg;
                        phase_acc_reg <= 1'b1;
                        state_reg     <= S_ADD0;
                    end
                    else
                    begin
                        state_reg <= S_LOOP1;
                    end
                end
                S_LOOP1:
                begin
                    d_reg <= d_reg >> 1;
                    if ((d_reg >> 1) != '0)
                    begin
                        ux_reg        <= px_reg;
                        uy_reg        <= py_reg;
                        uinf_reg      <= pinf_reg;
                        vx_reg        <= px_reg;
                        vy_reg        <= py_reg;
                        vinf_reg      <= pinf_reg;
                        phase_acc_reg <= 1'b0;
                        state_reg     <= S_ADD0;
                    end
                    else
                    begin
                        rx_reg    <= ax_reg;
                        ry_reg    <= ay_reg;
                        rinf_reg  <= ainf_reg;
                        state_reg <= S_FIN;
                    end
                end
                S_ADD0:
                begin
                    priority if (uinf_reg)
                    begin
                        rx_reg    <= vx_reg;
                        ry_reg    <= vy_reg;
                        rinf_reg  <= vinf_reg;
                        state_reg <= S_ADD_DONE;
                    end
                    else if (vinf_reg)
                    begin
                        rx_reg    <= ux_reg;
                        ry_reg    <= uy_reg;
                        rinf_reg  <= 1'b0;
                        state_reg <= S_ADD_DONE;
                    end
                    else if (ux_reg != vx_reg)
                    begin
                        t0_reg    <= subm(vy_reg, uy_reg, p_reg);
                        r0_reg    <= subm(vx_reg, ux_reg, p_reg);
                        r1_reg    <= p_reg;
                        s0_reg    <= FE_ONE;
                        s1_reg    <= '0;
                        state_reg <= S_INV_T;
                    end
                    else if (addm(uy_reg, vy_reg, p_reg) == '0)
                    begin
                        rx_reg    <= '0;
                        ry_reg    <= '0;
                        rinf_reg  <= 1'b1;
                        state_reg <= S_ADD_DONE;
                    end
                    else
                    begin
                        mul_a_reg <= ux_reg;
                        mul_b_reg <= ux_reg;
                        ret_reg   <= S_ADD1;
                        state_reg <= S_MUL;
                    end
                end
                S_ADD1:
                begin
                    mul_a_reg <= FE_THREE;
                    mul_b_reg <= mul_r_reg;
                    ret_reg   <= S_ADD2;
                    state_reg <= S_MUL;
                end
                S_ADD2:
                begin
                    t0_reg    <= addm(mul_r_reg, a_reg, p_reg);
                    r0_reg    <= addm(uy_reg, uy_reg, p_reg);
                    r1_reg    <= p_reg;
                    s0_reg    <= FE_ONE;
                    s1_reg    <= '0;
                    state_reg <= S_INV_T;
                end
                S_INV_T:
                begin
                    if (r1_reg == '0)
                    begin
                        mul_a_reg <= t0_reg;
                        mul_b_reg <= s0_reg;
                        ret_reg   <= S_ADD4;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        q_reg     <= r0_reg;
                        rem_reg   <= '0;
                        state_reg <= S_INV_D;
                    end
                end
                S_INV_D:
                begin
                    // Restoring division, one quotient bit a cycle.
                    if (rem_w >= {1'b0, r1_reg})
                    begin
                        rem_reg <= FIELD_BITS'(rem_w - {1'b0, r1_reg});
                        q_reg   <= {q_reg[FIELD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_w[FIELD_BITS-1:0];
                        q_reg   <= {q_reg[FIELD_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == CNT_W'(FIELD_BITS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_INV_M;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_INV_M:
                begin
                    mul_a_reg <= s1_reg;
                    mul_b_reg <= q_reg;
                    ret_reg   <= S_INV_U;
                    state_reg <= S_MUL;
                end
                S_INV_U:
                begin
                    r0_reg    <= r1_reg;
                    r1_reg    <= rem_reg;
                    s0_reg    <= s1_reg;
                    s1_reg    <= st_new;
                    state_reg <= S_INV_T;
                end
                S_ADD4:
                begin
                    k_reg     <= mul_r_reg;
                    mul_a_reg <= mul_r_reg;
                    mul_b_reg <= mul_r_reg;
                    ret_reg   <= S_ADD5;
                    state_reg <= S_MUL;
                end
                S_ADD5:
                begin
                    rx_reg    <= rx_new;
                    mul_a_reg <= k_reg;
                    mul_b_reg <= subm(ux_reg, rx_new, p_reg);
                    ret_reg   <= S_ADD6;
                    state_reg <= S_MUL;
                end
                S_ADD6:
                begin
                    ry_reg    <= subm(mul_r_reg, uy_reg, p_reg);
                    rinf_reg  <= 1'b0;
                    state_reg <= S_ADD_DONE;
                end
                S_ADD_DONE:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (phase_acc_reg)
                    begin
                        ax_reg    <= rx_reg;
                        ay_reg    <= ry_reg;
                        ainf_reg  <= rinf_reg;
                        state_reg <= S_LOOP1;
                    end
                    else
                    begin
                        px_reg    <= rx_reg;
                        py_reg    <= ry_reg;
                        pinf_reg  <= rinf_reg;
                        state_reg <= S_LOOP0;
                    end
                end
                S_MUL:
                begin
                    // MSB-first shift-and-add: acc = 2*acc + bit*u, all mod p.
                    mul_r_reg <= addm(addm(mul_r_reg, mul_r_reg, p_reg),
                                      mul_b_reg[FIELD_BITS-1] ? mul_a_reg : '0, p_reg);
                    mul_b_reg <= {mul_b_reg[FIELD_BITS-2:0], 1'b0};
                    if (cnt_reg == CNT_W'(FIELD_BITS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    done_reg                      <= 1'b1;
                    result_reg.point_error        <= err_reg;
                    result_reg.result_at_infinity <= err_reg || rinf_reg;
                    result_reg.result_x           <= (err_reg || rinf_reg) ? '0 : rx_reg;
                    result_reg.result_y           <= (err_reg || rinf_reg) ? '0 : ry_reg;
                    state_reg                     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted start");

    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.result_at_infinity) |->
        (result.result_x == '0 && result.result_y == '0))
        else $error("point at infinity with nonzero coordinates");

    a_err_inf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.point_error) |-> result.result_at_infinity)
        else $error("error result is not the point at infinity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_FIN && !busy))
        else $error("done strobe outside the finish step");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ecpa_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 64'd100_000_000;
    localparam longint unsigned P_DEFAULT   = 64'h7FFF_FFFF;

    typedef struct {
        longint unsigned x;
        longint unsigned y;
        bit              inf;
    } curve_pt_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    cmd_t           cmd;
    logic           done;
    res_t           result;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    // Current register contents as the testbench believes them.
    longint unsigned cur_a;
    longint unsigned cur_b;
    longint unsigned cur_p;
    // A known point on the current curve, base of the well-formed operands.
    curve_pt_t       base_pt;
    int              send_idle_pct;
    longint unsigned cycles;
    int              items_sent;

    ec_point_add_and_scalar_multiply i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    function automatic longint unsigned fld_add(longint unsigned u, longint unsigned v,
                                                longint unsigned p);
        longint unsigned s;
        s = u + v;
        return (s >= p) ? s - p : s;
    endfunction

    function automatic longint unsigned fld_sub(longint unsigned u, longint unsigned v,
                                                longint unsigned p);
        return (u >= v) ? u - v : u + (p - v);
    endfunction

    function automatic longint unsigned fld_mul(longint unsigned u, longint unsigned v,
                                                longint unsigned p);
        return (u * v) % p;
    endfunction

    // Extended Euclid; for a non-prime modulus the Bezout coefficient is kept as is.
    function automatic longint unsigned fld_inv(longint unsigned v, longint unsigned p);
        longint unsigned r0, r1, s0, s1, q, rt, st;
        r0 = v;
        r1 = p;
        s0 = 1;
        s1 = 0;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            rt = r0 - q * r1;
            st = fld_sub(s0, fld_mul(q % p, s1, p), p);
            r0 = r1;
            r1 = rt;
            s0 = s1;
            s1 = st;
        end
        return s0;
    endfunction

    function automatic bit on_curve(curve_pt_t q, longint unsigned a, longint unsigned b,
                                    longint unsigned p);
        longint unsigned lhs, rhs;
        if (q.inf)
        begin
            return 1'b1;
        end
        lhs = fld_mul(q.y, q.y, p);
        rhs = fld_mul(fld_mul(q.x, q.x, p), q.x, p);
        rhs = fld_add(rhs, fld_mul(a, q.x, p), p);
        rhs = fld_add(rhs, b, p);
        return lhs == rhs;
    endfunction

    function automatic curve_pt_t point_sum(curve_pt_t u, curve_pt_t v, longint unsigned a,
                                            longint unsigned p);
        curve_pt_t       r;
        longint unsigned k, num;
        if (u.inf)
        begin
            return v;
        end
        if (v.inf)
        begin
            return u;
        end
        r.inf = 1'b0;
        if (u.x != v.x)
        begin
            k = fld_mul(fld_sub(v.y, u.y, p), fld_inv(fld_sub(v.x, u.x, p), p), p);
        end
        else
        begin
            if (fld_add(u.y, v.y, p) == 0)
            begin
                r.x   = 0;
                r.y   = 0;
                r.inf = 1'b1;
                return r;
            end
            num = fld_add(fld_mul(3, fld_mul(u.x, u.x, p), p), a, p);
            k   = fld_mul(num, fld_inv(fld_add(u.y, u.y, p), p), p);
        end
        r.x = fld_sub(fld_sub(fld_mul(k, k, p), u.x, p), v.x, p);
        r.y = fld_sub(fld_mul(k, fld_sub(u.x, r.x, p), p), u.y, p);
        return r;
    endfunction

    // LSB-first double-and-add, the same walk as the block.
    function automatic curve_pt_t point_times(curve_pt_t g, longint unsigned d,
                                              longint unsigned a, longint unsigned p);
        curve_pt_t acc, pw;
        acc.x   = 0;
        acc.y   = 0;
        acc.inf = 1'b1;
        pw      = g;
        while (d != 0)
        begin
            if (d[0])
            begin
                acc = point_sum(acc, pw, a, p);
            end
            d = d >> 1;
            if (d != 0)
            begin
                pw = point_sum(pw, pw, a, p);
            end
        end
        return acc;
    endfunction

    function automatic res_t predict_point(cmd_t c, longint unsigned a_reg,
                                           longint unsigned b_reg, longint unsigned p);
        curve_pt_t f, s, r;
        bit        err;
        res_t      o;
        longint unsigned a, b;
        r.x   = 0;
        r.y   = 0;
        r.inf = 1'b1;
        err   = 1'b0;
        if (p < 5)
        begin
            err = 1'b1;
        end
        else
        begin
            a     = a_reg % p;
            b     = b_reg % p;
            f.x   = longint'(c.first_x) % p;
            f.y   = longint'(c.first_y) % p;
            f.inf = c.first_at_infinity;
            s.x   = longint'(c.second_x) % p;
            s.y   = longint'(c.second_y) % p;
            s.inf = c.second_at_infinity;
            if (!on_curve(f, a, b, p))
            begin
                err = 1'b1;
            end
            else if (c.opcode == OP_ADD)
            begin
                if (!on_curve(s, a, b, p))
                begin
                    err = 1'b1;
                end
                else
                begin
                    r = point_sum(f, s, a, p);
                end
            end
            else
            begin
                r = point_times(f, longint'(c.scalar), a, p);
            end
        end
        o.result_x           = (err || r.inf) ? '0 : fe_t'(r.x);
        o.result_y           = (err || r.inf) ? '0 : fe_t'(r.y);
        o.result_at_infinity = err || r.inf;
        o.point_error        = err;
        return o;
    endfunction

    class point_scoreboard;
        res_t pending_points[$];
        int   mismatches;
        int   results_seen;

        function void note_command(cmd_t c, longint unsigned a, longint unsigned b,
                                   longint unsigned p);
            pending_points.push_back(predict_point(c, a, b, p));
        endfunction

        function void report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endfunction

        function void check_result(res_t r);
            res_t e;
            results_seen++;
            if (pending_points.size() == 0)
            begin
                report($sformatf("unexpected result x=%0h y=%0h", r.result_x, r.result_y));
                return;
            end
            e = pending_points.pop_front();
            if (r.result_x !== e.result_x)
            begin
                report($sformatf("result_x %0h, expected %0h", r.result_x, e.result_x));
            end
            if (r.result_y !== e.result_y)
            begin
                report($sformatf("result_y %0h, expected %0h", r.result_y, e.result_y));
            end
            if (r.result_at_infinity !== e.result_at_infinity)
            begin
                report($sformatf("result_at_infinity %b, expected %b",
                                 r.result_at_infinity, e.result_at_infinity));
            end
            if (r.point_error !== e.point_error)
            begin
                report($sformatf("point_error %b, expected %b", r.point_error, e.point_error));
            end
        endfunction
    endclass

    point_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            sb.check_result(result);
        end
    end

    task automatic write_reg(logic [1:0] idx, longint unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value[31:0];
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_command(cmd_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        // The beat is taken at the first edge that sees busy low.
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        sb.note_command(c, cur_a, cur_b, cur_p);
        items_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (sb.pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic cmd_t blank_cmd();
        cmd_t c;
        c = '0;
        return c;
    endfunction

    function automatic curve_pt_t random_curve_pt();
        return point_times(base_pt, $urandom_range(1, 5000), cur_a % cur_p, cur_p);
    endfunction

    function automatic fe_t maybe_unreduced(longint unsigned v);
        if ($urandom_range(3) == 0 && v + cur_p <= P_DEFAULT)
        begin
            return fe_t'(v + cur_p);
        end
        return fe_t'(v);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t      c;
        curve_pt_t f, s;
        int        pick;
        c = '0;
        if (cur_p < 5 || $urandom_range(99) < 35)
        begin
            c.opcode             = $urandom_range(1);
            c.first_x            = fe_t'($urandom);
            c.first_y            = fe_t'($urandom);
            c.first_at_infinity  = ($urandom_range(7) == 0);
            c.second_x           = fe_t'($urandom);
            c.second_y           = fe_t'($urandom);
            c.second_at_infinity = ($urandom_range(7) == 0);
            c.scalar             = scalar_t'($urandom);
            return c;
        end
        f = random_curve_pt();
        pick = $urandom_range(5);
        if (pick == 0)
        begin
            s = f;
        end
        else if (pick == 1)
        begin
            s   = f;
            s.y = (cur_p - f.y) % cur_p;
        end
        else
        begin
            s = random_curve_pt();
        end
        c.first_x            = maybe_unreduced(f.x);
        c.first_y            = maybe_unreduced(f.y);
        c.first_at_infinity  = f.inf || ($urandom_range(15) == 0);
        c.second_x           = maybe_unreduced(s.x);
        c.second_y           = maybe_unreduced(s.y);
        c.second_at_infinity = s.inf || ($urandom_range(15) == 0);
        // Long scalars are slow, so most stay short and a rare one is full width.
        c.opcode = $urandom_range(1);
        if ($urandom_range(49) == 0)
        begin
            c.scalar = scalar_t'($urandom);
        end
        else if ($urandom_range(3) == 0)
        begin
            c.scalar = scalar_t'($urandom_range(255));
        end
        else
        begin
            c.scalar = scalar_t'($urandom_range(15));
        end
        return c;
    endfunction

    task automatic set_curve(longint unsigned p, longint unsigned a_reg);
        longint unsigned a, rhs;
        cur_p = p;
        cur_a = a_reg;
        if (p >= 5)
        begin
            // Pick a point and choose b so that it lies on the curve.
            a         = a_reg % p;
            base_pt.x = $urandom_range(32'h7FFF_FFFE) % p;
            base_pt.y = $urandom_range(32'h7FFF_FFFE) % p;
            base_pt.inf = 1'b0;
            rhs   = fld_add(fld_mul(fld_mul(base_pt.x, base_pt.x, p), base_pt.x, p),
                            fld_mul(a, base_pt.x, p), p);
            cur_b = fld_sub(fld_mul(base_pt.y, base_pt.y, p), rhs, p);
        end
        else
        begin
            cur_b = 64'd2147483646;
        end
        write_reg(REG_CURVE_A, cur_a);
        write_reg(REG_CURVE_B, cur_b);
        write_reg(REG_MODULUS, cur_p);
    endtask

    longint unsigned phase_p[10] = '{64'd5, 64'd2147483647, 64'd7, 64'd65521,
                                     64'd2147483629, 64'd15, 64'd0, 64'd3,
                                     64'd1000003, 64'd5};
    int idle_modes[3] = '{0, 80, 32};

    initial
    begin
        cmd_t c;
        sb            = new();
        cycles        = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cur_a   = 0;
        cur_b   = 0;
        cur_p   = P_DEFAULT;
        base_pt.x   = 1;
        base_pt.y   = 1;
        base_pt.inf = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset curve y^2 = x^3 mod 2^31-1, which holds (1,1).
        c = blank_cmd();
        c.first_x = 1; c.first_y = 1; c.second_x = 1; c.second_y = 1;
        send_command(c);
        c.second_y = fe_t'(P_DEFAULT - 1);
        send_command(c);
        c.first_at_infinity = 1'b1;
        send_command(c);
        c.first_at_infinity = 1'b0; c.second_at_infinity = 1'b1;
        send_command(c);
        c.first_at_infinity = 1'b1;
        send_command(c);
        c = blank_cmd();
        c.first_x = 2; c.first_y = 1; c.second_x = 1; c.second_y = 1;
        send_command(c);
        c.first_x = 1; c.second_x = 2;
        send_command(c);
        // All-ones coordinates reduce to (0,0), a point with y = 0.
        c = blank_cmd();
        c.first_x = '1; c.first_y = '1;
        send_command(c);
        c.opcode = OP_MUL; c.scalar = 2;
        send_command(c);
        c = blank_cmd();
        c.opcode = OP_MUL; c.first_x = 1; c.first_y = 1;
        send_command(c);
        c.scalar = 1;
        send_command(c);
        c.scalar = 13;
        send_command(c);
        c.scalar = '1;
        send_command(c);
        c.first_at_infinity = 1'b1;
        send_command(c);
        c = blank_cmd();
        c.opcode = OP_MUL; c.first_x = 3; c.first_y = 3; c.scalar = '1;
        send_command(c);
        drain();

        // Largest curve_a below the default modulus, so the block's reduction leaves it unchanged.
        set_curve(P_DEFAULT, 64'd2147483646);
        for (int i = 0; i < 4; i++)
        begin
            send_command(random_cmd());
        end
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            set_curve(phase_p[ph], (ph == 2) ? 64'd0 : 64'($urandom_range(32'h7FFF_FFFE)));
            send_idle_pct = idle_modes[ph % 3];
            for (int i = 0; i < ((phase_p[ph] < 5) ? 4 : 9); i++)
            begin
                send_command(random_cmd());
            end
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d commands (%0d results) over reset and 11 written curves,",
                 items_sent, sb.results_seen);
        $display("including tiny, non-prime and invalid moduli and sender gaps.");
        if (sb.mismatches == 0 && sb.pending_points.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_points.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
